// ===== src/hamming_top_k_matcher_defines.svh =====
// ----------------------------------------------------------------------------
// hamming_top_k_matcher_defines
// assertion macros shared by the matcher rtl
// ----------------------------------------------------------------------------
`ifndef HAMMING_TOP_K_MATCHER_DEFINES_SVH
`define HAMMING_TOP_K_MATCHER_DEFINES_SVH

// same-cycle implication, clocked on clk, off while in reset
`define HKM_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hkm assertion failed");

// next-cycle implication, clocked on clk, off while in reset
`define HKM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hkm assertion failed");

`endif

// ===== src/hkm_pkg.sv =====
// ----------------------------------------------------------------------------
// hkm_pkg
// shared constants, types and helpers of the hamming top-k matcher
// ----------------------------------------------------------------------------
package hkm_pkg;

	localparam int MAX_MATCHES = 16;
	localparam int ID_BITS     = 16;
	localparam int RESULT_CAP  = 16;

	localparam int HASH_W    = 64;
	localparam int ID_PORT_W = 16;
	localparam int DIST_W    = 7;
	localparam int MC_W      = 5;
	localparam int DATA_W    = 64;
	localparam int ADDR_W    = 4;

	localparam int ID_KEEP_W = (ID_BITS < ID_PORT_W) ? ID_BITS : ID_PORT_W;
	localparam int CNT_W     = $clog2(MAX_MATCHES + 1);
	localparam int LIM       = (MAX_MATCHES < RESULT_CAP) ? MAX_MATCHES : RESULT_CAP;
	localparam int CMP_W     = (CNT_W > MC_W) ? CNT_W : MC_W;
	localparam int NBYTES    = HASH_W / 8;

	// register index, taken from paddr bit 3
	localparam logic REG_TARGET = 1'b0;
	localparam logic REG_COUNT  = 1'b1;

	typedef struct packed {
		logic [ID_KEEP_W-1:0] id;
		logic [DIST_W-1:0]    distance;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic drain;
	} cell_ctl_t;

	function automatic logic [3:0] pop8(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			n = n + 4'(b[i]);
		end
		return n;
	endfunction

endpackage

// ===== src/hamming_top_k_matcher.sv =====
// ----------------------------------------------------------------------------
// hamming_top_k_matcher: an accepted word passes the stage 1 and stage 2 registers before its list insertion
// throughput one candidate word per cycle while in_ready is high, set by the insert-and-shift cell chain
// after a set's last word the input stalls while that word is in stage 1 or 2 and while its results drain
// results leave one per cycle while out_ready is high, from the head cell through one output register
// async reset: target 0, match count 1, list empty, pipeline and output idle
// ----------------------------------------------------------------------------
`include "hamming_top_k_matcher_defines.svh"

module hamming_top_k_matcher
	import hkm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready,
	// candidate words
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [HASH_W-1:0]    candidate_hash,
	input  logic [ID_PORT_W-1:0] candidate_id,
	input  logic                 carries_candidate,
	input  logic                 last_of_set,
	// result words
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ID_PORT_W-1:0] match_id,
	output logic [DIST_W-1:0]    match_distance,
	output logic                 no_match,
	output logic                 last_result
);

	// configuration registers
	logic [HASH_W-1:0] target_q;
	logic [MC_W-1:0]   match_count_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q      <= '0;
			match_count_q <= MC_W'(1);
		end else if (cfg_wr) begin
			unique case (paddr[3])
				REG_TARGET: target_q      <= pwdata;
				REG_COUNT:  match_count_q <= pwdata[MC_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			REG_TARGET: prdata = target_q;
			REG_COUNT:  prdata = DATA_W'(match_count_q);
			default:    prdata = '0;
		endcase
	end

	// stage 1: xor against the target, per-byte bit counts
	logic                 vld_s1, last_s1, carries_s1;
	logic [ID_KEEP_W-1:0] id_s1;
	logic [3:0]           bytecnt_s1 [NBYTES];
	logic [HASH_W-1:0]    diff;
	logic                 in_acc;

	// stage 2: full hamming distance
	logic                 vld_s2, last_s2, carries_s2;
	logic [ID_KEEP_W-1:0] id_s2;
	logic [DIST_W-1:0]    dist_s2;
	logic [DIST_W-1:0]    dist_sum;

	// list and drain control
	logic [CNT_W-1:0] fill_q;
	logic             seen_q;
	logic             draining_q;
	logic             nomatch_q;
	logic [CNT_W-1:0] drain_left_q;

	// output register
	logic                 out_valid_q;
	logic [ID_PORT_W-1:0] match_id_q;
	logic [DIST_W-1:0]    match_distance_q;
	logic                 no_match_q;
	logic                 last_result_q;

	// hold the input off while a set's last word is in flight or results drain
	assign in_ready = !(draining_q || (vld_s1 && last_s1) || (vld_s2 && last_s2));
	assign in_acc   = in_valid && in_ready;
	assign diff     = candidate_hash ^ target_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_acc;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			last_s1    <= last_of_set;
			carries_s1 <= carries_candidate;
			id_s1      <= candidate_id[ID_KEEP_W-1:0];
			for (int b = 0; b < NBYTES; b++) begin
				bytecnt_s1[b] <= pop8(diff[b*8 +: 8]);
			end
		end
		if (vld_s1) begin
			last_s2    <= last_s1;
			carries_s2 <= carries_s1;
			id_s2      <= id_s1;
			dist_s2    <= dist_sum;
		end
	end

	// adder over the byte counts, eight narrow steps
	always_comb begin
		dist_sum = '0;
		for (int b = 0; b < NBYTES; b++) begin
			dist_sum = dist_sum + DIST_W'(bytecnt_s1[b]);
		end
	end

	// cell chain
	cell_ctl_t ctl;
	entry_t    new_entry;
	entry_t    cell_q    [MAX_MATCHES];
	logic      cell_take [MAX_MATCHES];
	logic      drain_go;

	assign new_entry.id       = id_s2;
	assign new_entry.distance = dist_s2;
	assign drain_go           = draining_q && (!out_valid_q || out_ready);
	assign ctl.insert         = vld_s2 && carries_s2;
	assign ctl.drain          = drain_go && !nomatch_q;

	for (genvar g = 0; g < MAX_MATCHES; g++) begin : g_cell
		entry_t prev_e, next_e;
		logic   prev_t;

		if (g == 0) begin : g_head
			assign prev_e = new_entry;
			assign prev_t = 1'b0;
		end else begin : g_body
			assign prev_e = cell_q[g-1];
			assign prev_t = cell_take[g-1];
		end

		// tail has nothing behind it while draining
		if (g == MAX_MATCHES - 1) begin : g_tail
			assign next_e = new_entry;
		end else begin : g_inner
			assign next_e = cell_q[g+1];
		end

		hkm_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (fill_q > CNT_W'(g)),
			.new_entry  (new_entry),
			.prev_entry (prev_e),
			.prev_take  (prev_t),
			.next_entry (next_e),
			.entry      (cell_q[g]),
			.take       (cell_take[g])
		);
	end

	// fill after this word, and how many results the set reports
	logic [CNT_W-1:0] fill_ins;
	logic             seen_nx;
	logic [CMP_W-1:0] k_mc, k_fill, k_val;

	always_comb begin
		fill_ins = fill_q;
		if (carries_s2 && (fill_q < CNT_W'(MAX_MATCHES))) begin
			fill_ins = fill_q + CNT_W'(1);
		end
		seen_nx = seen_q || carries_s2;
		k_mc    = CMP_W'(match_count_q);
		k_fill  = CMP_W'(fill_ins);
		k_val   = (k_mc < CMP_W'(LIM)) ? k_mc : CMP_W'(LIM);
		if (k_fill < k_val) begin
			k_val = k_fill;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			seen_q       <= 1'b0;
			draining_q   <= 1'b0;
			nomatch_q    <= 1'b0;
			drain_left_q <= '0;
		end else begin
			if (vld_s2) begin
				if (last_s2) begin
					// list is emptied for the next set; cells keep data for the drain
					fill_q <= '0;
					seen_q <= 1'b0;
					if (!seen_nx) begin
						draining_q   <= 1'b1;
						nomatch_q    <= 1'b1;
						drain_left_q <= CNT_W'(1);
					end else if (k_val != '0) begin
						draining_q   <= 1'b1;
						nomatch_q    <= 1'b0;
						drain_left_q <= CNT_W'(k_val);
					end
				end else begin
					fill_q <= fill_ins;
					seen_q <= seen_nx;
				end
			end
			if (drain_go) begin
				drain_left_q <= drain_left_q - CNT_W'(1);
				if (drain_left_q == CNT_W'(1)) begin
					draining_q <= 1'b0;
				end
			end
		end
	end

	// output register, loaded from the head cell, or cleared for a no-match result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (drain_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (drain_go) begin
			match_id_q       <= nomatch_q ? '0 : ID_PORT_W'(cell_q[0].id);
			match_distance_q <= nomatch_q ? '0 : cell_q[0].distance;
			no_match_q       <= nomatch_q;
			last_result_q    <= (drain_left_q == CNT_W'(1));
		end
	end

	assign out_valid      = out_valid_q;
	assign match_id       = match_id_q;
	assign match_distance = match_distance_q;
	assign no_match       = no_match_q;
	assign last_result    = last_result_q;

	// checks
	`HKM_ASSERT_IMPL(a_no_accept_in_drain, draining_q, !in_ready)
	`HKM_ASSERT_IMPL(a_drain_count_range, draining_q,
		(drain_left_q != '0) && (drain_left_q <= CNT_W'(LIM)))
	`HKM_ASSERT_IMPL(a_fill_bounded, 1'b1, fill_q <= CNT_W'(MAX_MATCHES))
	`HKM_ASSERT_IMPL(a_nomatch_is_last, out_valid_q && no_match_q, last_result_q)
	`HKM_ASSERT_NEXT(a_last_ends_drain, drain_go && (drain_left_q == CNT_W'(1)), !draining_q)

endmodule

// ===== src/hkm_cell.sv =====
// ----------------------------------------------------------------------------
// hkm_cell
// one slot of the sorted match list: insert-and-shift on a new candidate,
// shift towards the head while results drain
// ----------------------------------------------------------------------------
module hkm_cell
	import hkm_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occupied,
	input  entry_t    new_entry,
	input  entry_t    prev_entry,
	input  logic      prev_take,
	input  entry_t    next_entry,
	output entry_t    entry,
	output logic      take
);

	entry_t entry_q;

	// newcomer lands here if strictly better, or slot is free; ties stay ahead
	assign take  = !occupied || (new_entry.distance < entry_q.distance);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (prev_take) begin
				entry_q <= prev_entry;
			end else if (take) begin
				entry_q <= new_entry;
			end
		end else if (ctl.drain) begin
			entry_q <= next_entry;
		end
	end

endmodule
